// ----- src/sseq_pkg.sv -----
// ----------------------------------------------------------------------------
// sseq_pkg
// Shared widths, command codes and register indexes for the step sequencer.
// ----------------------------------------------------------------------------
package sseq_pkg;

    // Default geometry of the pattern.
    localparam int CHANNELS_DEF = 5;
    localparam int STEPS_DEF    = 16;
    localparam int SUBTICKS_DEF = 6;

    // Field widths of the request and event streams.
    localparam int CMD_W     = 3;
    localparam int CHAN_W    = 3;
    localparam int STEP_IN_W = 4;
    localparam int NOTE_W    = 8;
    localparam int LEN_W     = 8;

    // Packed bus widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [7:0] TEMPO_DIV_RESET = 8'd10;

    // Request commands; codes 6 and 7 carry no meaning and are ignored.
    typedef enum logic [CMD_W-1:0] {
        CMD_INT_TICK   = 3'd0,
        CMD_MIDI_CLOCK = 3'd1,
        CMD_PLAY       = 3'd2,
        CMD_STOP       = 3'd3,
        CMD_CONTINUE   = 3'd4,
        CMD_WRITE      = 3'd5
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TEMPO_DIVISOR  = 2'd0,
        REG_EXTERNAL_CLOCK = 2'd1,
        REG_CLOCK_SCALE    = 2'd2
    } cfg_reg_t;

endpackage

// ----- src/step_sequencer_note_events.sv -----
// ----------------------------------------------------------------------------
// step_sequencer_note_events
// Multi-channel step sequencer that turns clock and transport requests into
// note-on and note-off events, with the pattern held in an entry memory.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload
// s_*       in         tuser: command; tdata: channel, step, note_value, note_length
// m_*       out        tuser: event_kind; tdata: event_channel, event_note;
//                      tlast: last_event
// cfg_*     in         write enable, register index, data
//
// Play, continue, write and non-firing clock requests leave the block ready.
// A firing tick or a stop scans every channel and then flushes the last event:
// the entry memory has one read port, so channels are read one per cycle
// while the scan is not stalled. A stalled event output holds the scan only
// while the output register and the one-event holding slot are both full.
// Reset clears the counters, the transport and all entry valid bits, so
// every pattern entry reads as a rest with note zero until written.
// ----------------------------------------------------------------------------
module step_sequencer_note_events #(
    parameter int CHANNELS          = sseq_pkg::CHANNELS_DEF,
    parameter int STEPS             = sseq_pkg::STEPS_DEF,
    parameter int SUBTICKS_PER_STEP = sseq_pkg::SUBTICKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // channel[2:0], step[6:3], note_value[14:7], note_length[22:15], zero fill
    input  logic [sseq_pkg::S_TDATA_W-1:0]  s_tdata,
    // command[2:0]
    input  logic [sseq_pkg::CMD_W-1:0]      s_tuser,
    // Event stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // event_channel[2:0], event_note[10:3], zero fill
    output logic [sseq_pkg::M_TDATA_W-1:0]  m_tdata,
    // event_kind[0]
    output logic                            m_tuser,
    output logic                            m_tlast,
    // Configuration writes
    input  logic                            cfg_we,
    input  logic [sseq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sseq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sseq_pkg::*;

    localparam int DEPTH   = CHANNELS * STEPS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int STEP_W  = $clog2(STEPS);
    localparam int SUB_W   = $clog2(SUBTICKS_PER_STEP);
    localparam int ENTRY_W = NOTE_W + LEN_W;

    localparam logic [ADDR_W-1:0] STEPS_A   = ADDR_W'(STEPS);
    localparam logic [CHAN_W-1:0] LAST_CH   = CHAN_W'(CHANNELS - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);
    localparam logic [SUB_W-1:0]  LAST_SUB  = SUB_W'(SUBTICKS_PER_STEP - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic              kind;
        logic [CHAN_W-1:0] chan;
        logic [NOTE_W-1:0] note;
    } event_t;

    // Request fields.
    cmd_t                 cmd;
    logic [CHAN_W-1:0]    in_chan;
    logic [STEP_IN_W-1:0] in_step;
    logic [NOTE_W-1:0]    in_note;
    logic [LEN_W-1:0]     in_len;

    // Configuration registers.
    logic [7:0] tempo_div_reg;
    logic       ext_clock_reg;
    logic [2:0] clock_scale_reg;

    // Sequencer state.
    state_t             state_reg;
    logic [STEP_W-1:0]  cur_step_reg;
    logic [SUB_W-1:0]   sub_tick_reg;
    logic [7:0]         tempo_count_reg;
    logic [7:0]         midi_count_reg;
    logic               running_reg;
    logic               scan_stop_reg;
    logic [CHAN_W-1:0]  ch_reg;
    logic [CHAN_W-1:0]  ch_next;

    // Event held back until the next one shows whether it is the last.
    logic   pend_valid_reg;
    event_t pend_reg;
    event_t cur_event;

    // Output register.
    logic   out_valid_reg;
    event_t out_reg;
    logic   out_last_reg;

    // Entry memory and its valid bits.
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   vld_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_vld_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               mem_we;

    // Decode and handshake.
    logic [7:0]        tempo_inc;
    logic [7:0]        midi_inc;
    logic [7:0]        midi_target;
    logic              write_ok;
    logic [LEN_W-1:0]  ent_len;
    logic [NOTE_W-1:0] ent_note;
    logic              hit;
    logic              out_free;
    logic              scan_go;

    assign cmd     = cmd_t'(s_tuser);
    assign in_chan = s_tdata[2:0];
    assign in_step = s_tdata[6:3];
    assign in_note = s_tdata[14:7];
    assign in_len  = s_tdata[22:15];

    assign s_tready = (state_reg == ST_IDLE);

    // Divider counters and the entry write check.
    assign tempo_inc   = tempo_count_reg + 8'd1;
    assign midi_inc    = midi_count_reg + 8'd1;
    assign midi_target = 8'd1 << clock_scale_reg;
    assign write_ok    = ({1'b0, in_chan} < 4'(CHANNELS)) &&
                         ({3'b000, in_step} < 7'(STEPS));
    assign wr_addr     = ADDR_W'(in_chan) * STEPS_A + ADDR_W'(in_step);
    assign mem_we      = s_tready && s_tvalid && (cmd == CMD_WRITE) && write_ok;

    // Entry of the channel under evaluation; an unwritten entry is a rest.
    assign ent_len  = rd_vld_reg ? rd_data_reg[ENTRY_W-1:NOTE_W] : '0;
    assign ent_note = rd_vld_reg ? rd_data_reg[NOTE_W-1:0] : '0;

    // Event decision for the current channel.
    always_comb
    begin
        if (scan_stop_reg)
        begin
            hit = (ent_len != '0);
        end
        else if (sub_tick_reg == '0)
        begin
            hit = (ent_len != '0);
        end
        else
        begin
            hit = (ent_len == LEN_W'(sub_tick_reg));
        end
        cur_event.kind = scan_stop_reg || (sub_tick_reg != '0);
        cur_event.chan = ch_reg;
        cur_event.note = ent_note;
    end

    // The scan stalls only when a new event meets a full pending slot and a
    // blocked output register.
    assign out_free = !out_valid_reg || m_tready;
    assign scan_go  = !hit || !pend_valid_reg || out_free;

    // Channel to read next; a stalled scan reads the same entry again.
    always_comb
    begin
        if (state_reg == ST_SCAN && !scan_go)
        begin
            ch_next = ch_reg;
        end
        else if (state_reg == ST_SCAN && ch_reg != LAST_CH)
        begin
            ch_next = ch_reg + 3'd1;
        end
        else
        begin
            ch_next = '0;
        end
    end

    assign rd_addr = ADDR_W'(ch_next) * STEPS_A + ADDR_W'(cur_step_reg);

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= {in_len, in_note};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Valid bits of the entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // Control state, configuration and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            tempo_div_reg   <= TEMPO_DIV_RESET;
            ext_clock_reg   <= 1'b0;
            clock_scale_reg <= 3'd0;
            cur_step_reg    <= '0;
            sub_tick_reg    <= '0;
            tempo_count_reg <= '0;
            midi_count_reg  <= '0;
            running_reg     <= 1'b0;
            scan_stop_reg   <= 1'b0;
            ch_reg          <= '0;
            pend_valid_reg  <= 1'b0;
            pend_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            ch_reg <= ch_next;

            // Configuration writes.
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_TEMPO_DIVISOR:  tempo_div_reg   <= cfg_data;
                    REG_EXTERNAL_CLOCK: ext_clock_reg   <= cfg_data[0];
                    REG_CLOCK_SCALE:    clock_scale_reg <= cfg_data[2:0];
                    default:            ;
                endcase
            end

            // The output register empties when taken; loads below override.
            if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        unique case (cmd)
                            CMD_INT_TICK:
                            begin
                                if (!ext_clock_reg && running_reg)
                                begin
                                    if (tempo_inc == tempo_div_reg)
                                    begin
                                        tempo_count_reg <= '0;
                                        scan_stop_reg   <= 1'b0;
                                        state_reg       <= ST_SCAN;
                                    end
                                    else
                                    begin
                                        tempo_count_reg <= tempo_inc;
                                    end
                                end
                            end
                            CMD_MIDI_CLOCK:
                            begin
                                if (ext_clock_reg && running_reg)
                                begin
                                    if (midi_inc == midi_target)
                                    begin
                                        midi_count_reg <= '0;
                                        scan_stop_reg  <= 1'b0;
                                        state_reg      <= ST_SCAN;
                                    end
                                    else
                                    begin
                                        midi_count_reg <= midi_inc;
                                    end
                                end
                            end
                            CMD_PLAY:
                            begin
                                running_reg  <= 1'b1;
                                cur_step_reg <= '0;
                            end
                            CMD_STOP:
                            begin
                                running_reg     <= 1'b0;
                                tempo_count_reg <= '0;
                                midi_count_reg  <= '0;
                                sub_tick_reg    <= '0;
                                scan_stop_reg   <= 1'b1;
                                state_reg       <= ST_SCAN;
                            end
                            CMD_CONTINUE:
                            begin
                                running_reg <= 1'b1;
                            end
                            default:
                            begin
                                // Entry writes go to the memory; others are ignored.
                            end
                        endcase
                    end
                end

                ST_SCAN:
                begin
                    if (scan_go)
                    begin
                        if (hit)
                        begin
                            // A newer event means the pending one is not the last.
                            if (pend_valid_reg)
                            begin
                                out_valid_reg <= 1'b1;
                                out_reg       <= pend_reg;
                                out_last_reg  <= 1'b0;
                            end
                            pend_reg       <= cur_event;
                            pend_valid_reg <= 1'b1;
                        end
                        if (ch_reg == LAST_CH)
                        begin
                            state_reg <= ST_FLUSH;
                            // A tick moves the position once all channels are seen.
                            if (!scan_stop_reg)
                            begin
                                if (sub_tick_reg == LAST_SUB)
                                begin
                                    sub_tick_reg <= '0;
                                    if (cur_step_reg == LAST_STEP)
                                    begin
                                        cur_step_reg <= '0;
                                    end
                                    else
                                    begin
                                        cur_step_reg <= cur_step_reg + STEP_W'(1);
                                    end
                                end
                                else
                                begin
                                    sub_tick_reg <= sub_tick_reg + SUB_W'(1);
                                end
                            end
                        end
                    end
                end

                ST_FLUSH:
                begin
                    // The pending event, if any, is the last of this request.
                    if (!pend_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_reg        <= pend_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - CHAN_W - NOTE_W){1'b0}}, out_reg.note, out_reg.chan};

endmodule

// ----- src/sseq_checker.sv -----
// ----------------------------------------------------------------------------
// sseq_checker
// Port-level checks of the step sequencer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sseq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [sseq_pkg::CMD_W-1:0]      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sseq_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);
    import sseq_pkg::*;

    // A stalled event holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("event payload changed while stalled");

    // The request side goes busy only after taking a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
    else $error("request ready dropped without an accepted request");

    // Play, continue and entry writes never produce events, so the block stays ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_PLAY || s_tuser == CMD_CONTINUE
            || s_tuser == CMD_WRITE) |=> s_tready)
    else $error("transport or write request made the block busy");

    // New events are loaded only while a request is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
    else $error("event appeared while the block was idle");

endmodule

bind step_sequencer_note_events sseq_checker u_sseq_checker (.*);
